### rtl/imlq_pkg.sv
// Shared types and codes for the indexed multi-list queue.
`timescale 1ns / 1ps

package imlq_pkg;

    // Field widths of the request and result payloads
    localparam int CMD_W    = 1;
    localparam int LIST_W   = 4;
    localparam int ENTRY_W  = 6;
    localparam int STATUS_W = 2;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_APPEND = 1'b0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 1'b1;

    // Status codes
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [LIST_W-1:0]  list_id;
        logic [ENTRY_W-1:0] entry_index;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ENTRY_W-1:0]  head_entry;
        logic                list_empty;
    } out_item_t;

endpackage

### rtl/indexed_multi_list_queue_core.sv
// Top level of the indexed multi-list queue: sequencer plus output register.
`timescale 1ns / 1ps

// Usage:
// Several singly linked lists share one table of entry slots. A request on
// s_valid/s_ready/s_data carries a command (append at tail or remove), a list
// id and an entry slot. Every request yields exactly one result on
// m_valid/m_ready/m_data: a status, the list's head afterwards and an empty
// flag. One request is worked at a time; s_ready is low while it runs.
// An append reads the list's head and tail, links the new entry, then
// terminates it. A remove reads the head and tail, then follows up to
// NUM_ENTRIES links, one next-link RAM read per cycle; on a hit it unlinks
// the entry and nulls its link. A list out of range skips the table read;
// an entry out of range, or a remove from an empty list, is answered after
// it. After reset the head, tail and next-link tables are swept to null,
// one row per cycle over max(NUM_ENTRIES, NUM_LISTS) rows, with s_ready low.
// The result register holds a finished result while m_ready is low; the next
// request is still accepted and runs until its own result is ready, then
// waits for the register to drain.
module indexed_multi_list_queue_core import imlq_pkg::*; #(
    parameter int NUM_ENTRIES = 64,
    parameter int NUM_LISTS   = 16
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    logic      res_valid;
    logic      res_ready;
    out_item_t res_data;
    logic      m_valid_reg;
    out_item_t m_data_reg;

    imlq_ctrl #(
        .NUM_ENTRIES (NUM_ENTRIES),
        .NUM_LISTS   (NUM_LISTS)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_data  (s_data),
        .req_valid (s_valid),
        .req_ready (s_ready),
        .res_data  (res_data),
        .res_valid (res_valid),
        .res_ready (res_ready)
    );

    // Load the output register when it is empty or draining
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_data_reg <= res_data;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

### rtl/imlq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module imlq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/imlq_ctrl.sv
// Sequencer for list tables: clearing pass, append, and link walk for remove.
`timescale 1ns / 1ps

module imlq_ctrl import imlq_pkg::*; #(
    parameter int NUM_ENTRIES = 64,
    parameter int NUM_LISTS   = 16
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  in_item_t  req_data,
    input  logic      req_valid,
    output logic      req_ready,
    output out_item_t res_data,
    output logic      res_valid,
    input  logic      res_ready
);

    localparam int PW    = $clog2(NUM_ENTRIES + 1);
    localparam int AW    = $clog2(NUM_ENTRIES);
    localparam int LAW   = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
    localparam int CLR_N = (NUM_ENTRIES > NUM_LISTS) ? NUM_ENTRIES : NUM_LISTS;
    localparam int CW    = $clog2(CLR_N);

    localparam logic [PW-1:0] NIL      = PW'(NUM_ENTRIES);
    localparam logic [PW-1:0] WALK_MAX = PW'(NUM_ENTRIES);
    localparam logic [CW-1:0] CLR_LAST = CW'(CLR_N - 1);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RD_HT,
        S_APP_LINK,
        S_APP_TERM,
        S_WALK,
        S_UNL_LINK,
        S_UNL_TERM,
        S_RESP
    } state_t;

    state_t          state_reg;
    logic [CW-1:0]   clr_idx_reg;
    logic [CMD_W-1:0] cmd_reg;
    logic [LAW-1:0]  lst_reg;
    logic [PW-1:0]   ent_reg;
    logic            ent_oob_reg;
    logic [PW-1:0]   head_reg;
    logic [PW-1:0]   tail_reg;
    logic [PW-1:0]   cur_reg;
    logic [PW-1:0]   prev_reg;
    logic [PW-1:0]   nxt_reg;
    logic [PW-1:0]   step_reg;
    out_item_t       res_reg;

    logic [PW-1:0]  head_rd;
    logic [PW-1:0]  tail_rd;
    logic [PW-1:0]  next_rd;
    logic           head_we;
    logic [LAW-1:0] head_waddr;
    logic [PW-1:0]  head_wdata;
    logic [LAW-1:0] head_raddr;
    logic           tail_we;
    logic [LAW-1:0] tail_waddr;
    logic [PW-1:0]  tail_wdata;
    logic [LAW-1:0] tail_raddr;
    logic           next_we;
    logic [AW-1:0]  next_waddr;
    logic [PW-1:0]  next_wdata;
    logic [AW-1:0]  next_raddr;

    logic head_null;
    logic tail_null;
    logic cur_hit;

    // Build a result from a status and the list head afterwards
    function automatic out_item_t make_result(input logic [STATUS_W-1:0] st,
                                              input logic [PW-1:0] ptr);
        out_item_t r;
        r.status     = st;
        r.list_empty = (ptr >= NIL);
        r.head_entry = r.list_empty ? '0 : ENTRY_W'(ptr);
        return r;
    endfunction

    assign head_null = (head_reg >= NIL);
    assign tail_null = (tail_reg >= NIL);
    // Compare the current walk position against the requested entry
    assign cur_hit   = (cur_reg == ent_reg);

    // Table storage
    imlq_ram #(.WIDTH(PW), .DEPTH(NUM_LISTS)) u_head_ram (
        .aclk  (aclk),
        .we    (head_we),
        .waddr (head_waddr),
        .wdata (head_wdata),
        .raddr (head_raddr),
        .rdata (head_rd)
    );

    imlq_ram #(.WIDTH(PW), .DEPTH(NUM_LISTS)) u_tail_ram (
        .aclk  (aclk),
        .we    (tail_we),
        .waddr (tail_waddr),
        .wdata (tail_wdata),
        .raddr (tail_raddr),
        .rdata (tail_rd)
    );

    imlq_ram #(.WIDTH(PW), .DEPTH(NUM_ENTRIES)) u_next_ram (
        .aclk  (aclk),
        .we    (next_we),
        .waddr (next_waddr),
        .wdata (next_wdata),
        .raddr (next_raddr),
        .rdata (next_rd)
    );

    // Drive table ports from the current step
    always_comb begin
        head_raddr = LAW'(req_data.list_id);
        tail_raddr = LAW'(req_data.list_id);
        next_raddr = AW'(cur_reg);
        head_we    = 1'b0;
        head_waddr = lst_reg;
        head_wdata = NIL;
        tail_we    = 1'b0;
        tail_waddr = lst_reg;
        tail_wdata = NIL;
        next_we    = 1'b0;
        next_waddr = AW'(ent_reg);
        next_wdata = NIL;
        unique case (state_reg)
            S_CLEAR: begin
                head_we    = (32'(clr_idx_reg) < NUM_LISTS);
                tail_we    = (32'(clr_idx_reg) < NUM_LISTS);
                next_we    = (32'(clr_idx_reg) < NUM_ENTRIES);
                head_waddr = LAW'(clr_idx_reg);
                tail_waddr = LAW'(clr_idx_reg);
                next_waddr = AW'(clr_idx_reg);
            end
            S_RD_HT: begin
                next_raddr = AW'(head_rd);
            end
            S_APP_LINK: begin
                if (head_null || tail_null) begin
                    head_we    = 1'b1;
                    head_wdata = ent_reg;
                end else begin
                    next_we    = 1'b1;
                    next_waddr = AW'(tail_reg);
                    next_wdata = ent_reg;
                end
            end
            S_APP_TERM: begin
                next_we    = 1'b1;
                next_waddr = AW'(ent_reg);
                tail_we    = 1'b1;
                tail_wdata = ent_reg;
            end
            S_WALK: begin
                next_raddr = AW'(next_rd);
            end
            S_UNL_LINK: begin
                if (prev_reg >= NIL) begin
                    head_we    = 1'b1;
                    head_wdata = nxt_reg;
                end else begin
                    next_we    = 1'b1;
                    next_waddr = AW'(prev_reg);
                    next_wdata = nxt_reg;
                end
                if (tail_reg == cur_reg) begin
                    tail_we    = 1'b1;
                    tail_wdata = prev_reg;
                end
            end
            S_UNL_TERM: begin
                next_we    = 1'b1;
                next_waddr = AW'(cur_reg);
            end
            default: begin
            end
        endcase
    end

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_idx_reg <= '0;
        end else begin
            unique case (state_reg)
                // Sweep every table row to null
                S_CLEAR: begin
                    clr_idx_reg <= clr_idx_reg + 1'b1;
                    if (clr_idx_reg == CLR_LAST) begin
                        state_reg <= S_IDLE;
                    end
                end
                // Take a request and start the head/tail read
                S_IDLE: begin
                    if (req_valid) begin
                        cmd_reg     <= req_data.command;
                        lst_reg     <= LAW'(req_data.list_id);
                        ent_reg     <= PW'(req_data.entry_index);
                        ent_oob_reg <= (32'(req_data.entry_index) >= NUM_ENTRIES);
                        if (32'(req_data.list_id) >= NUM_LISTS) begin
                            res_reg   <= make_result(STATUS_NOT_FOUND, NIL);
                            state_reg <= S_RESP;
                        end else begin
                            state_reg <= S_RD_HT;
                        end
                    end
                end
                // Capture head and tail, then dispatch
                S_RD_HT: begin
                    head_reg <= head_rd;
                    tail_reg <= tail_rd;
                    cur_reg  <= head_rd;
                    prev_reg <= NIL;
                    step_reg <= '0;
                    if (ent_oob_reg) begin
                        res_reg   <= make_result(STATUS_NOT_FOUND, head_rd);
                        state_reg <= S_RESP;
                    end else if (cmd_reg == CMD_APPEND) begin
                        state_reg <= S_APP_LINK;
                    end else if (head_rd >= NIL) begin
                        res_reg   <= make_result(STATUS_EMPTY, head_rd);
                        state_reg <= S_RESP;
                    end else begin
                        state_reg <= S_WALK;
                    end
                end
                S_APP_LINK: begin
                    state_reg <= S_APP_TERM;
                end
                // Terminate the new entry and report the head
                S_APP_TERM: begin
                    res_reg   <= make_result(STATUS_OK,
                                             (head_null || tail_null) ? ent_reg : head_reg);
                    state_reg <= S_RESP;
                end
                // Advance one link per cycle until hit, end of chain or bound
                S_WALK: begin
                    if (step_reg == WALK_MAX) begin
                        res_reg   <= make_result(STATUS_NOT_FOUND, head_reg);
                        state_reg <= S_RESP;
                    end else if (cur_hit) begin
                        nxt_reg   <= next_rd;
                        state_reg <= S_UNL_LINK;
                    end else if (next_rd >= NIL) begin
                        res_reg   <= make_result(STATUS_NOT_FOUND, head_reg);
                        state_reg <= S_RESP;
                    end else begin
                        prev_reg <= cur_reg;
                        cur_reg  <= next_rd;
                        step_reg <= step_reg + 1'b1;
                    end
                end
                S_UNL_LINK: begin
                    state_reg <= S_UNL_TERM;
                end
                // Null the removed entry's link and report the head
                S_UNL_TERM: begin
                    res_reg   <= make_result(STATUS_OK,
                                             (prev_reg >= NIL) ? nxt_reg : head_reg);
                    state_reg <= S_RESP;
                end
                // Hold the result until the output stage takes it
                S_RESP: begin
                    if (res_ready) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign req_ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_RESP);
    assign res_data  = res_reg;

`ifndef SYNTH
    // The walk only ever stands on a real slot
    a_walk_cur_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WALK) |-> (cur_reg < NIL))
        else $error("walk position is null");

    // The step count never passes the bound
    a_walk_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WALK) |-> (step_reg <= WALK_MAX))
        else $error("walk step count overran");

    // The first walk step has no predecessor
    a_walk_first_prev: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WALK && step_reg == '0) |-> (prev_reg == NIL))
        else $error("predecessor set on first walk step");

    // Unlink only acts on the requested entry
    a_unlink_target: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_UNL_LINK) |-> (cur_reg == ent_reg && cur_reg < NIL))
        else $error("unlink on wrong entry");
`endif

endmodule
